// File: design/fnvh_pkg.sv
// Shared constants, command type and mixing function for the FNV-1a 128-bit hasher.
package fnvh_pkg;

  localparam logic [127:0] FNV_BASIS = 128'h6C62272E07BB0142_62B821756295C58D;

  // Trailer byte positions hashed after the last byte of a name step.
  localparam int TRAIL_CNT_W = 3;
  localparam logic [TRAIL_CNT_W-1:0] TRAIL_NUL  = 3'd0;
  localparam logic [TRAIL_CNT_W-1:0] TRAIL_OCC0 = 3'd1;
  localparam logic [TRAIL_CNT_W-1:0] TRAIL_OCC1 = 3'd2;
  localparam logic [TRAIL_CNT_W-1:0] TRAIL_OCC2 = 3'd3;
  localparam logic [TRAIL_CNT_W-1:0] TRAIL_OCC3 = 3'd4;
  localparam logic [TRAIL_CNT_W-1:0] TRAIL_BOOL = 3'd5;

  localparam logic REQ_RAW  = 1'b0;
  localparam logic REQ_NAME = 1'b1;

  typedef struct packed {
    logic                   acc;            // input transfer this cycle
    logic                   trail;          // hash one trailer byte
    logic [TRAIL_CNT_W-1:0] trail_idx;      // which trailer byte
    logic                   out_load;       // load the digest register
    logic                   out_from_state; // load it from the stored state
  } fnvh_cmd_t;

  // One FNV-1a round: xor the byte into the low eight bits, then multiply by
  // the prime 2^88 + 0x13B modulo 2^128, written as shifts and adds.
  function automatic logic [127:0] fnv_mix(input logic [127:0] s, input logic [7:0] b);
    logic [127:0] x;
    x = {s[127:8], s[7:0] ^ b};
    return (x << 8) + (x << 5) + (x << 4) + (x << 3) + (x << 1) + x + (x << 88);
  endfunction

endpackage

// File: design/fnvh_dp.sv
// Datapath: hash state, trailer operand registers and the digest register.
module fnvh_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  fnvh_pkg::fnvh_cmd_t cmd,
  input  logic                in_first_item,
  input  logic [63:0]         in_seed_hi,
  input  logic [63:0]         in_seed_lo,
  input  logic                in_byte_present,
  input  logic [7:0]          in_data_byte,
  input  logic [31:0]         in_occurrence,
  input  logic [7:0]          in_bool_op,
  output logic [63:0]         out_digest_hi,
  output logic [63:0]         out_digest_lo
);

  logic [127:0] hash_r, hash_nxt;
  logic [127:0] digest_r;
  logic [31:0]  occ_r;
  logic [7:0]   bool_r;
  logic [127:0] seeded;
  logic [127:0] mix_src;
  logic [7:0]   mix_byte;
  logic [7:0]   trail_byte;
  logic         do_mix;

  always_comb begin
    case (cmd.trail_idx)
      fnvh_pkg::TRAIL_NUL:  trail_byte = 8'h00;
      fnvh_pkg::TRAIL_OCC0: trail_byte = occ_r[7:0];
      fnvh_pkg::TRAIL_OCC1: trail_byte = occ_r[15:8];
      fnvh_pkg::TRAIL_OCC2: trail_byte = occ_r[23:16];
      fnvh_pkg::TRAIL_OCC3: trail_byte = occ_r[31:24];
      fnvh_pkg::TRAIL_BOOL: trail_byte = bool_r;
      default:              trail_byte = 8'h00;
    endcase
  end

  always_comb begin
    if (!in_first_item) begin
      seeded = hash_r;
    end else if (in_seed_hi == 64'd0 && in_seed_lo == 64'd0) begin
      seeded = fnvh_pkg::FNV_BASIS;
    end else begin
      seeded = {in_seed_hi, in_seed_lo};
    end
    mix_src  = cmd.trail ? hash_r : seeded;
    mix_byte = cmd.trail ? trail_byte : in_data_byte;
    do_mix   = cmd.trail || in_byte_present;
    hash_nxt = do_mix ? fnvh_pkg::fnv_mix(mix_src, mix_byte) : mix_src;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= fnvh_pkg::FNV_BASIS;
    end else if (cmd.acc || cmd.trail) begin
      hash_r <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      occ_r  <= in_occurrence;
      bool_r <= in_bool_op;
    end
    if (cmd.out_load) begin
      digest_r <= cmd.out_from_state ? hash_r : hash_nxt;
    end
  end

  assign out_digest_hi = digest_r[127:64];
  assign out_digest_lo = digest_r[63:0];

endmodule

// File: design/fnvh_ctrl.sv
// Controller: input and output handshakes, trailer sequencing and result slot tracking.
module fnvh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_req_type,
  input  logic                in_last_item,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output fnvh_pkg::fnvh_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TRAIL = 2'd1;
  localparam logic [1:0] ST_HOLD  = 2'd2;

  logic [1:0]                       state_r, state_nxt;
  logic [fnvh_pkg::TRAIL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_free;

  // The digest register is free when empty or when its transfer happens now.
  assign out_free = !out_valid_r || !out_stall;

  // A last item needs the result slot; other items only need the block idle.
  assign in_stall  = (state_r != ST_IDLE) || (in_last_item && !out_free);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt          = state_r;
    cnt_nxt            = cnt_r;
    cmd                = '0;
    cmd.trail_idx      = cnt_r;
    cmd.acc            = in_valid && !in_stall;
    case (state_r)
      ST_IDLE: begin
        if (cmd.acc && in_last_item) begin
          if (in_req_type == fnvh_pkg::REQ_NAME) begin
            state_nxt = ST_TRAIL;
            cnt_nxt   = fnvh_pkg::TRAIL_NUL;
          end else begin
            cmd.out_load = 1'b1;
          end
        end
      end
      ST_TRAIL: begin
        cmd.trail = 1'b1;
        if (cnt_r == fnvh_pkg::TRAIL_BOOL) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.out_load       = 1'b1;
          cmd.out_from_state = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= fnvh_pkg::TRAIL_NUL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/fnv1a_128_chained_id_hasher_top.sv
// Top level of the chained 128-bit FNV-1a identifier hasher.
// An input item is taken in any cycle in which in_stall is low; a last item waits while an earlier digest is stalled.
// A raw last item shows its digest on out_valid the cycle after its transfer.
// A name-step last item then hashes six trailer bytes in order, with in_stall high,
// and its digest is registered after the last trailer byte once the result slot is free.
// Synchronous active-low reset loads the FNV-128 offset basis and empties the output.
module fnv1a_128_chained_id_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic        in_first_item,
  input  logic [63:0] in_seed_hi,
  input  logic [63:0] in_seed_lo,
  input  logic        in_byte_present,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_item,
  input  logic [31:0] in_occurrence,
  input  logic [7:0]  in_bool_op,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_hi,
  output logic [63:0] out_digest_lo
);

  fnvh_pkg::fnvh_cmd_t cmd;

  fnvh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_req_type  (in_req_type),
    .in_last_item (in_last_item),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd)
  );

  fnvh_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_first_item   (in_first_item),
    .in_seed_hi      (in_seed_hi),
    .in_seed_lo      (in_seed_lo),
    .in_byte_present (in_byte_present),
    .in_data_byte    (in_data_byte),
    .in_occurrence   (in_occurrence),
    .in_bool_op      (in_bool_op),
    .out_digest_hi   (out_digest_hi),
    .out_digest_lo   (out_digest_lo)
  );

endmodule

// File: design/fnvh_checker.sv
// Port-level checker for the hasher, bound to the top level.
module fnvh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_req_type,
  input logic        in_last_item,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_digest_hi,
  input logic [63:0] out_digest_lo
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_digest_hi) && $stable(out_digest_lo))
    else $error("result changed while stalled");

  // A raw last item produces its digest on the next cycle.
  a_raw_digest: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_item && in_req_type == fnvh_pkg::REQ_RAW
    |=> out_valid)
    else $error("raw digest missing");

  // A name-step last item blocks input while its trailer is hashed.
  a_trail_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_item && in_req_type == fnvh_pkg::REQ_NAME
    |=> in_stall)
    else $error("input taken during trailer");

endmodule

bind fnv1a_128_chained_id_hasher_top fnvh_checker u_fnvh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_req_type   (in_req_type),
  .in_last_item  (in_last_item),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_digest_hi (out_digest_hi),
  .out_digest_lo (out_digest_lo)
);

// File: sim/tb_fnv1a_128_chained_id_hasher_top.sv
// Self-checking testbench for the chained 128-bit FNV-1a identifier hasher.
module tb_fnv1a_128_chained_id_hasher_top;

  localparam bit [127:0] OFFSET_BASIS = 128'h6C62272E07BB0142_62B821756295C58D;
  localparam bit [127:0] FNV_PRIME    = 128'h0000000001000000_000000000000013B;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 16;

  typedef struct {
    logic        req_type;
    bit          first_item;
    bit   [63:0] seed_hi;
    bit   [63:0] seed_lo;
    bit          byte_present;
    bit   [7:0]  data_byte;
    bit          last_item;
    bit   [31:0] occurrence;
    bit   [7:0]  bool_op;
  } hash_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic        in_first_item;
  logic [63:0] in_seed_hi;
  logic [63:0] in_seed_lo;
  logic        in_byte_present;
  logic [7:0]  in_data_byte;
  logic        in_last_item;
  logic [31:0] in_occurrence;
  logic [7:0]  in_bool_op;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_digest_hi;
  logic [63:0] out_digest_lo;

  bit   [127:0] id_state;
  bit   [127:0] expected_digests[$];
  bit   [127:0] last_digest;
  int           fail_count;
  int           cycle_count;
  int           items_sent;
  int           digests_seen;
  int           name_digests;
  int           input_stall_cycles;
  int           rx_hold_cycles;
  bit           tx_idle;
  bit           rx_idle;

  fnv1a_128_chained_id_hasher_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_first_item  (in_first_item),
    .in_seed_hi     (in_seed_hi),
    .in_seed_lo     (in_seed_lo),
    .in_byte_present(in_byte_present),
    .in_data_byte   (in_data_byte),
    .in_last_item   (in_last_item),
    .in_occurrence  (in_occurrence),
    .in_bool_op     (in_bool_op),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digest_hi  (out_digest_hi),
    .out_digest_lo  (out_digest_lo)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && in_valid && in_stall) begin
      input_stall_cycles <= input_stall_cycles + 1;
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_fnv1a_128_chained_id_hasher_top failed");
      $finish;
    end
  end

  // One FNV-1a round: xor the byte into the low bits, multiply by the prime mod 2^128.
  function automatic bit [127:0] fnv_round(input bit [127:0] s, input bit [7:0] b);
    return (s ^ {120'd0, b}) * FNV_PRIME;
  endfunction

  task automatic advance_id_hash(input hash_item_t it);
    bit [127:0] seed;
    seed = {it.seed_hi, it.seed_lo};
    if (it.first_item) begin
      id_state = (seed == '0) ? OFFSET_BASIS : seed;
    end
    if (it.byte_present) begin
      id_state = fnv_round(id_state, it.data_byte);
    end
    if (it.last_item) begin
      if (it.req_type == fnvh_pkg::REQ_NAME) begin
        id_state = fnv_round(id_state, 8'h00);
        id_state = fnv_round(id_state, it.occurrence[7:0]);
        id_state = fnv_round(id_state, it.occurrence[15:8]);
        id_state = fnv_round(id_state, it.occurrence[23:16]);
        id_state = fnv_round(id_state, it.occurrence[31:24]);
        id_state = fnv_round(id_state, it.bool_op);
        name_digests++;
      end
      expected_digests.push_back(id_state);
      last_digest = id_state;
    end
  endtask

  // Called in the time step of a rising edge; returns in the step of the accepting edge.
  task automatic send_item(input hash_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req_type     <= it.req_type;
    in_first_item   <= it.first_item;
    in_seed_hi      <= it.seed_hi;
    in_seed_lo      <= it.seed_lo;
    in_byte_present <= it.byte_present;
    in_data_byte    <= it.data_byte;
    in_last_item    <= it.last_item;
    in_occurrence   <= it.occurrence;
    in_bool_op      <= it.bool_op;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    advance_id_hash(it);
    items_sent++;
  endtask

  function automatic hash_item_t make_item(input logic req, input bit first, input bit last,
                                           input bit [127:0] seed, input bit present,
                                           input bit [7:0] data, input bit [31:0] occ,
                                           input bit [7:0] op);
    hash_item_t it;
    it.req_type     = req;
    it.first_item   = first;
    it.seed_hi      = seed[127:64];
    it.seed_lo      = seed[63:0];
    it.byte_present = present;
    it.data_byte    = data;
    it.last_item    = last;
    it.occurrence   = occ;
    it.bool_op      = op;
    return it;
  endfunction

  function automatic hash_item_t random_item();
    hash_item_t it;
    it.req_type = $urandom_range(0, 1) ? fnvh_pkg::REQ_NAME : fnvh_pkg::REQ_RAW;
    case ($urandom_range(0, 5))
      0, 1:    {it.seed_hi, it.seed_lo} = '0;
      2:       {it.seed_hi, it.seed_lo} = '1;
      3:       {it.seed_hi, it.seed_lo} = {64'd0, $urandom, $urandom};
      default: {it.seed_hi, it.seed_lo} = {$urandom, $urandom, $urandom, $urandom};
    endcase
    it.byte_present = ($urandom_range(0, 7) != 0);
    it.data_byte    = 8'($urandom);
    it.occurrence   = ($urandom_range(0, 7) == 0) ? {32{$urandom_range(0, 1) == 1}} : $urandom;
    it.bool_op      = 8'($urandom);
    it.first_item   = 1'b0;
    it.last_item    = 1'b0;
    return it;
  endfunction

  // The very first message continues from the offset basis loaded by reset.
  task automatic test_reset_basis();
    send_item(make_item(fnvh_pkg::REQ_RAW, 1'b0, 1'b1, '0, 1'b1, 8'h61, 32'd0, 8'h00));
  endtask

  task automatic test_field_extremes();
    send_item(make_item(fnvh_pkg::REQ_RAW, 1'b1, 1'b0, '0, 1'b1, 8'h00, '1, 8'hFF));
    send_item(make_item(fnvh_pkg::REQ_RAW, 1'b0, 1'b1, '1, 1'b1, 8'hFF, '1, 8'hFF));
    // An empty message with a nonzero parent returns the parent itself.
    send_item(make_item(fnvh_pkg::REQ_RAW, 1'b1, 1'b1, '1, 1'b0, 8'hFF, 32'd0, 8'h00));
    send_item(make_item(fnvh_pkg::REQ_RAW, 1'b1, 1'b1, 128'd1, 1'b1, 8'hFF, 32'd0, 8'h00));
    send_item(make_item(fnvh_pkg::REQ_RAW, 1'b1, 1'b1, {1'b1, 127'd0}, 1'b0, 8'h00,
                        32'd0, 8'h00));
    send_item(make_item(fnvh_pkg::REQ_RAW, 1'b1, 1'b1, {64'd0, 64'h8000_0000_0000_0000},
                        1'b1, 8'h80, 32'd0, 8'h00));
  endtask

  task automatic test_name_steps();
    send_item(make_item(fnvh_pkg::REQ_NAME, 1'b1, 1'b1, '0, 1'b0, 8'h00, 32'd0, 8'h00));
    send_item(make_item(fnvh_pkg::REQ_NAME, 1'b1, 1'b0, {$urandom, $urandom, $urandom, $urandom},
                        1'b1, 8'h61, 32'd0, 8'h00));
    send_item(make_item(fnvh_pkg::REQ_RAW, 1'b0, 1'b0, '0, 1'b1, 8'h62, '1, 8'hFF));
    send_item(make_item(fnvh_pkg::REQ_NAME, 1'b0, 1'b1, '0, 1'b1, 8'h63, '1, 8'hFF));
    send_item(make_item(fnvh_pkg::REQ_NAME, 1'b1, 1'b1, '1, 1'b1, 8'h7F, 32'h8000_0001, 8'h80));
    send_item(make_item(fnvh_pkg::REQ_NAME, 1'b1, 1'b1, {64'h0, 64'h1}, 1'b1, 8'h00,
                        32'h0123_4567, 8'h01));
  endtask

  // Messages without a first item continue from the digest left by the one before.
  task automatic test_chaining();
    send_item(make_item(fnvh_pkg::REQ_RAW, 1'b0, 1'b1, '1, 1'b1, 8'h2F, '1, 8'hFF));
    send_item(make_item(fnvh_pkg::REQ_NAME, 1'b0, 1'b1, '1, 1'b0, 8'h00, 32'd7, 8'h02));
    send_item(make_item(fnvh_pkg::REQ_NAME, 1'b1, 1'b0, last_digest, 1'b1, 8'h70, 32'd0, 8'h00));
    send_item(make_item(fnvh_pkg::REQ_NAME, 1'b0, 1'b1, '0, 1'b1, 8'h71, 32'd3, 8'h01));
    send_item(make_item(fnvh_pkg::REQ_RAW, 1'b1, 1'b1, '0, 1'b0, 8'h00, 32'd0, 8'h00));
  endtask

  task automatic test_random_messages(input int n_items);
    hash_item_t it;
    int         len;
    int         k;
    int         sent;
    bit         chained;
    sent = 0;
    while (sent < n_items) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      chained = ($urandom_range(0, 7) == 0);
      for (k = 0; k < len; k++) begin
        it = random_item();
        it.first_item = (k == 0) && !chained;
        it.last_item  = (k == len - 1);
        send_item(it);
        sent++;
      end
    end
  endtask

  // The receiver holds off while a steady flow of short messages backs up into the input.
  task automatic test_input_backpressure();
    hash_item_t it;
    int         k;
    tx_idle = 1'b0;
    rx_hold_cycles = 80;
    for (k = 0; k < 30; k++) begin
      it = random_item();
      it.first_item = 1'b1;
      it.last_item  = 1'b1;
      send_item(it);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else begin
        int wait_cycles;
        wait_cycles = rx_idle ? $urandom_range(0, 3) : 0;
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (!out_valid);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_digests.size() == 0) begin
        $error("unexpected digest transfer: digest_hi=%h digest_lo=%h",
               out_digest_hi, out_digest_lo);
        fail_count++;
      end else begin
        bit [127:0] want;
        want = expected_digests.pop_front();
        digests_seen++;
        if (out_digest_hi !== want[127:64]) begin
          $error("digest_hi mismatch: expected %h, actual %h", want[127:64], out_digest_hi);
          fail_count++;
        end
        if (out_digest_lo !== want[63:0]) begin
          $error("digest_lo mismatch: expected %h, actual %h", want[63:0], out_digest_lo);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_req_type     <= fnvh_pkg::REQ_RAW;
    in_first_item   <= 1'b0;
    in_seed_hi      <= '0;
    in_seed_lo      <= '0;
    in_byte_present <= 1'b0;
    in_data_byte    <= '0;
    in_last_item    <= 1'b0;
    in_occurrence   <= '0;
    in_bool_op      <= '0;
    id_state        = OFFSET_BASIS;
    last_digest     = OFFSET_BASIS;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    rx_hold_cycles  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_basis();
    test_field_extremes();
    test_name_steps();
    test_chaining();
    test_random_messages(600);
    test_input_backpressure();
    test_random_messages(600);

    in_valid <= 1'b0;
    while (expected_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items and checked %0d digests, %0d of them name steps.",
             items_sent, digests_seen, name_digests);
    $display("The input was held back on %0d cycles.", input_stall_cycles);
    if (fail_count == 0) begin
      $display("tb_fnv1a_128_chained_id_hasher_top passed");
    end else begin
      $display("tb_fnv1a_128_chained_id_hasher_top failed");
    end
    $finish;
  end

endmodule
